// ===== rtl/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder: surrogate
// ranges and the job record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // surrogate ranges and supplementary plane base
    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_END   = 16'hE000;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;

    // limits of the one and two byte forms
    localparam logic [20:0] LIM_ONE_BYTE   = 21'h00080;
    localparam logic [20:0] LIM_TWO_BYTE   = 21'h00800;

    // byte used on error results
    localparam logic [7:0]  ERR_BYTE       = 8'h00;

    // number of result slots in one job
    localparam int unsigned JOB_SLOTS      = 4;
    localparam int unsigned SLOT_IDX_W     = $clog2(JOB_SLOTS);

    // one job: the whole run of results caused by one input unit
    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0]  bytes;
        logic [JOB_SLOTS-1:0]       bad;
        logic [SLOT_IDX_W-1:0]      last_idx;
    } u2u8_job_t;

endpackage

// ===== rtl/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// u2u8_front
// Front end: accepts code units, tracks a pending high surrogate and turns
// each unit into a job of up to four result bytes for the back end.
// ----------------------------------------------------------------------------
module u2u8_front
    import u2u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_string_end,
    output logic        job_valid,
    input  logic        job_ready,
    output u2u8_job_t   job
);

    logic       high_pending_reg, high_pending_next;
    logic [9:0] high_bits_reg, high_bits_next;

    logic       is_high, is_low, is_nul;
    logic       pair_done, err_first, tail_has, take;
    logic [20:0] pair_cp;
    u2u8_job_t  pair_job, unit_job, tail_job, job_out;

    // utf-8 byte layout of one code point
    function automatic u2u8_job_t encode_cp(input logic [20:0] cp);
        u2u8_job_t j;
        j = '0;
        if (cp < LIM_ONE_BYTE) begin
            j.bytes[0] = cp[7:0];
            j.last_idx = SLOT_IDX_W'(0);
        end else if (cp < LIM_TWO_BYTE) begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = SLOT_IDX_W'(1);
        end else if (cp < SUPP_BASE) begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = SLOT_IDX_W'(2);
        end else begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = SLOT_IDX_W'(3);
        end
        return j;
    endfunction

    // classify the incoming unit
    assign is_high = (s_code_unit >= SURR_HIGH_BASE) && (s_code_unit < SURR_LOW_BASE);
    assign is_low  = (s_code_unit >= SURR_LOW_BASE) && (s_code_unit < SURR_LOW_END);
    assign is_nul  = (s_code_unit == 16'h0000);

    assign pair_done = high_pending_reg && is_low;
    assign err_first = high_pending_reg && !is_low;
    assign pair_cp   = SUPP_BASE + {1'b0, high_bits_reg, s_code_unit[9:0]};

    assign pair_job = encode_cp(pair_cp);
    assign unit_job = encode_cp({5'b00000, s_code_unit});

    // results for the current unit once any pending error is dealt with
    always_comb begin
        tail_job = '0;
        tail_has = 1'b0;
        if (pair_done) begin
            tail_job = pair_job;
            tail_has = 1'b1;
        end else if (is_high) begin
            if (s_string_end) begin
                tail_job.bytes[0] = ERR_BYTE;
                tail_job.bad[0]   = 1'b1;
                tail_has          = 1'b1;
            end
        end else if (is_low) begin
            tail_job.bytes[0] = ERR_BYTE;
            tail_job.bad[0]   = 1'b1;
            tail_has          = 1'b1;
        end else if (!is_nul) begin
            tail_job = unit_job;
            tail_has = 1'b1;
        end
    end

    // prepend the unpaired-high error where one is due
    always_comb begin
        job_out = tail_job;
        if (err_first) begin
            job_out.bytes    = {tail_job.bytes[JOB_SLOTS-2:0], ERR_BYTE};
            job_out.bad      = {tail_job.bad[JOB_SLOTS-2:0], 1'b1};
            job_out.last_idx = tail_has ? tail_job.last_idx + SLOT_IDX_W'(1)
                                        : SLOT_IDX_W'(0);
        end
    end

    assign s_ready   = job_ready;
    assign job_valid = s_valid && (err_first || tail_has);
    assign job       = job_out;
    assign take      = s_valid && s_ready;

    // surrogate state for the next unit
    always_comb begin
        high_pending_next = high_pending_reg;
        high_bits_next    = high_bits_reg;
        if (take) begin
            if (!pair_done && is_high && !s_string_end) begin
                high_pending_next = 1'b1;
                high_bits_next    = s_code_unit[9:0];
            end else begin
                high_pending_next = 1'b0;
                high_bits_next    = 10'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_pending_reg <= 1'b0;
            high_bits_reg    <= 10'd0;
        end else begin
            high_pending_reg <= high_pending_next;
            high_bits_reg    <= high_bits_next;
        end
    end

endmodule

// ===== rtl/u2u8_queue.sv =====
// ----------------------------------------------------------------------------
// u2u8_queue
// Two-entry job queue between front end and back end, so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module u2u8_queue
    import u2u8_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  u2u8_job_t in_job,
    output logic      out_valid,
    input  logic      out_ready,
    output u2u8_job_t out_job
);

    u2u8_job_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = entry_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ===== rtl/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// u2u8_back
// Back end: walks through the slots of the head job, one result per cycle
// unless stalled, into an output register; marks the last result of each run.
// ----------------------------------------------------------------------------
module u2u8_back
    import u2u8_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      job_valid,
    output logic      job_ready,
    input  u2u8_job_t job,
    output logic      m_valid,
    input  logic      m_ready,
    output logic [7:0] m_out_byte,
    output logic      m_run_last,
    output logic      m_bad_input
);

    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            out_byte_reg;
    logic                  run_last_reg, bad_input_reg;
    logic                  load, at_last;

    assign load    = job_valid && (!m_valid_reg || m_ready);
    assign at_last = (idx_reg == job.last_idx);

    // release the job as its last slot moves into the output register
    assign job_ready = load && at_last;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            idx_next     = at_last ? SLOT_IDX_W'(0) : idx_reg + SLOT_IDX_W'(1);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg  <= job.bytes[idx_reg];
            bad_input_reg <= job.bad[idx_reg];
            run_last_reg  <= at_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_run_last  = run_last_reg;
    assign m_bad_input = bad_input_reg;

endmodule

// ===== rtl/utf16_to_utf8_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// UTF-16 to UTF-8 transcoder with surrogate pairing and error reporting.
// ----------------------------------------------------------------------------
// Code units are taken one per cycle while the two-entry job queue has room;
// each unit becomes a run of zero to four result bytes, and the output side
// delivers one byte per cycle while m_ready is high, from a registered output
// stage. The byte rate of the back end sets the sustained throughput: an ASCII
// unit gives one byte, a BMP unit up to three, and a surrogate pair four bytes
// for its two units; an unpaired-high error ahead of a unit adds one more byte.
// A NUL unit, or a high surrogate waiting for its partner, produces no
// transfer. Error results (unpaired high, lone low) carry a zero byte with
// m_bad_input set; m_run_last marks the final transfer caused by each input
// unit.
module utf16_to_utf8_transcoder_core
    import u2u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_string_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_bad_input
);

    logic      fe_valid, fe_ready;
    u2u8_job_t fe_job;
    logic      be_valid, be_ready;
    u2u8_job_t be_job;

    // classify units and build jobs
    u2u8_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_unit  (s_code_unit),
        .s_string_end (s_string_end),
        .job_valid    (fe_valid),
        .job_ready    (fe_ready),
        .job          (fe_job)
    );

    // decoupling queue
    u2u8_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_job    (fe_job),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_job   (be_job)
    );

    // serialise jobs into byte transfers
    u2u8_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (be_valid),
        .job_ready   (be_ready),
        .job         (be_job),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_bad_input (m_bad_input)
    );

endmodule

// ===== rtl/u2u8_checker.sv =====
// ----------------------------------------------------------------------------
// u2u8_checker
// Port-level checks on the transcoder's result channel, bound to the top.
// ----------------------------------------------------------------------------
module u2u8_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_run_last,
    input logic        m_bad_input
);

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_run_last) && $stable(m_bad_input))
        else $error("result changed while stalled");

    // nothing offered straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // error results carry a zero byte
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_input |-> m_out_byte == 8'h00)
        else $error("error result with nonzero byte");

    // a multi-byte lead byte never ends a run
    a_lead_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_input && m_out_byte[7:6] == 2'b11 |-> !m_run_last)
        else $error("lead byte marked last");

    // a single-byte character always ends its run
    a_ascii_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_input && !m_out_byte[7] |-> m_run_last)
        else $error("ascii byte not marked last");

endmodule

bind utf16_to_utf8_transcoder_core u2u8_checker u_checker (.*);

// ===== test/utf16_to_utf8_checker.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_checker
// Watches both channels of the transcoder. Every code unit transfer is run
// through a local UTF-16 to UTF-8 predictor, and the bytes it should cause are
// queued. Every output transfer is compared with the oldest queued byte.
// ----------------------------------------------------------------------------
module utf16_to_utf8_checker
    import u2u8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_string_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_run_last,
    input  logic        m_bad_input,
    output int          fail_count,
    output int          pending
);

    // one output byte as it should appear on the result channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } utf8_beat_t;

    // predictor state: held high surrogate
    logic         high_held;
    logic [9:0]   high_part;

    utf8_beat_t   expected_beats[$];
    utf8_beat_t   run_beats[$];
    int           mismatches = 0;

    function automatic void push_beat(input logic [7:0] data, input logic bad);
        utf8_beat_t beat;
        beat.data = data;
        beat.last = 1'b0;
        beat.bad  = bad;
        run_beats = {run_beats, beat};
    endfunction

    // utf-8 byte sequence of one code point
    function automatic void encode_code_point(input logic [20:0] cp);
        if (cp < LIM_ONE_BYTE) begin
            push_beat(cp[7:0], 1'b0);
        end else if (cp < LIM_TWO_BYTE) begin
            push_beat({3'b110, cp[10:6]}, 1'b0);
            push_beat({2'b10, cp[5:0]}, 1'b0);
        end else if (cp < SUPP_BASE) begin
            push_beat({4'b1110, cp[15:12]}, 1'b0);
            push_beat({2'b10, cp[11:6]}, 1'b0);
            push_beat({2'b10, cp[5:0]}, 1'b0);
        end else begin
            push_beat({5'b11110, cp[20:18]}, 1'b0);
            push_beat({2'b10, cp[17:12]}, 1'b0);
            push_beat({2'b10, cp[11:6]}, 1'b0);
            push_beat({2'b10, cp[5:0]}, 1'b0);
        end
    endfunction

    // bytes caused by one code unit, appended to the expected queue
    function automatic void predict_unit(input logic [15:0] unit, input logic at_end);
        logic        is_high;
        logic        is_low;
        logic        paired;
        logic [20:0] cp;
        run_beats.delete();
        is_high = (unit >= SURR_HIGH_BASE) && (unit < SURR_LOW_BASE);
        is_low  = (unit >= SURR_LOW_BASE) && (unit < SURR_LOW_END);
        paired  = 1'b0;

        // a held high surrogate either pairs or is reported as unpaired
        if (high_held) begin
            high_held = 1'b0;
            if (is_low) begin
                cp     = SUPP_BASE + {1'b0, high_part, unit[9:0]};
                paired = 1'b1;
                encode_code_point(cp);
            end else begin
                push_beat(ERR_BYTE, 1'b1);
            end
            high_part = '0;
        end

        // the unit on its own
        if (!paired) begin
            if (is_high) begin
                if (at_end) begin
                    push_beat(ERR_BYTE, 1'b1);
                end else begin
                    high_held = 1'b1;
                    high_part = unit[9:0];
                end
            end else if (is_low) begin
                push_beat(ERR_BYTE, 1'b1);
            end else if (unit != 16'h0000) begin
                encode_code_point({5'b0, unit});
            end
        end

        if (run_beats.size() > 0) begin
            run_beats[run_beats.size() - 1].last = 1'b1;
        end
        expected_beats = {expected_beats, run_beats};
    endfunction

    // compare output transfers, then predict from input transfers
    always @(posedge aclk) begin
        utf8_beat_t want;
        if (!aresetn) begin
            high_held = 1'b0;
            high_part = '0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected transfer: byte %h last %b bad %b",
                                 m_out_byte, m_run_last, m_bad_input);
                    end
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    if (m_out_byte !== want.data || m_run_last !== want.last ||
                        m_bad_input !== want.bad) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.data, want.last, want.bad,
                                     m_out_byte, m_run_last, m_bad_input);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_unit(s_code_unit, s_string_end);
            end
        end
        fail_count <= mismatches;
        pending    <= expected_beats.size();
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the transcoder testbench. Drives a directed set of code units and
// then random strings, mostly well-formed surrogate pairs and BMP characters
// with some broken sequences, through phases of sender idling and receiver
// stalling. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb
    import u2u8_pkg::*;
();

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit  = 16'h0000;
    logic        s_string_end = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_bad_input;

    int          fail_count;
    int          pending;
    int          idle_pct     = 0;
    int          stall_pct    = 0;

    int          phase_idle[4]  = '{0, 75, 0, 38};
    int          phase_stall[4] = '{0, 0, 75, 38};

    // clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    utf16_to_utf8_transcoder_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_unit  (s_code_unit),
        .s_string_end (s_string_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_bad_input  (m_bad_input)
    );

    utf16_to_utf8_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_unit  (s_code_unit),
        .s_string_end (s_string_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_bad_input  (m_bad_input),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // one code unit transfer, with random idle cycles ahead of it
    task automatic send_unit(input logic [15:0] unit, input logic at_end);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_code_unit  <= unit;
        s_string_end <= at_end;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // random strings: mostly pairs and plain characters, some broken input
    task automatic send_random_units(input int units);
        int          sent;
        int          pick;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] unit;
        logic        at_end;
        sent = 0;
        while (sent < units) begin
            pick   = $urandom_range(99);
            at_end = ($urandom_range(7) == 0);
            hi     = SURR_HIGH_BASE | 16'($urandom_range(1023));
            lo     = SURR_LOW_BASE | 16'($urandom_range(1023));
            if (pick < 30) begin
                send_unit(hi, 1'b0);
                send_unit(lo, at_end);
                sent += 2;
            end else begin
                if (pick < 50) begin
                    unit = 16'($urandom_range(127, 1));
                end else if (pick < 62) begin
                    unit = 16'($urandom_range(16'h07FF, 16'h0080));
                end else if (pick < 76) begin
                    // three-byte range, skipping the surrogates
                    unit = 16'($urandom_range(16'hF7FF, 16'h0800));
                    if (unit >= SURR_HIGH_BASE) unit = unit + 16'h0800;
                end else if (pick < 88) begin
                    unit = 16'($urandom());
                end else if (pick < 93) begin
                    unit = 16'h0000;
                end else if (pick < 97) begin
                    unit   = hi;
                    at_end = 1'($urandom_range(1));
                end else begin
                    unit = lo;
                end
                send_unit(unit, at_end);
                sent += 1;
            end
        end
    endtask

    // hold the sender until every expected byte has been seen
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each utf-8 length at its limits
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007F, 1'b1);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // lowest and highest supplementary code points
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // unpaired high followed by a plain unit, by another high, by nul
        send_unit(16'hD834, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0000, 1'b0);
        // high at end of string, lone lows
        send_unit(16'hDABC, 1'b1);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        drain();

        // random phases with different idling and stalling
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct <= phase_stall[p];
            send_random_units(52);
            if (p == 1) drain();
        end

        // wait out the tail
        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
